// ===== sv/lmsfe_pkg.sv =====
// Package with the shared types, codes and checksum function of the laser frame engine.
package lmsfe_pkg;

    // Item kinds on the request channel.
    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_RX_BYTE = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;

    // Result kinds.
    localparam logic KIND_CMD_BYTE   = 1'b0;
    localparam logic KIND_COMPLETION = 1'b1;

    // Completion status codes above the module status range.
    localparam logic [2:0] STATUS_COMM_ERR = 3'd4;
    localparam logic [2:0] STATUS_FAIL     = 3'd5;

    // Reset value of the timeout register and default result queue depth.
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam int          RES_QUEUE_DEPTH = 4;

    // One queued result: a whole four-byte command frame or one completion.
    typedef struct packed {
        logic        kind;
        logic [31:0] frame;
        logic [2:0]  status;
        logic [15:0] read_data;
        logic        mismatch;
    } t_res_entry;

    // BIP-4 over a four-byte frame, ignoring the checksum nibble of byte 0.
    function automatic logic [3:0] bip4(input logic [31:0] f);
        logic [7:0] x;
        x = {4'h0, f[27:24]} ^ f[23:16] ^ f[15:8] ^ f[7:0];
        return x[7:4] ^ x[3:0];
    endfunction

endpackage

// ===== sv/lmsfe_if.sv =====
// Channel interfaces of the laser frame engine: requests, results and configuration.
interface lmsfe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  reg_addr;
    logic        write_en;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, mode, reg_addr, write_en, write_data, rx_byte,
                    input ready);
    modport sink (input valid, mode, reg_addr, write_en, write_data, rx_byte,
                  output ready);
endinterface

interface lmsfe_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  result_status;
    logic [15:0] read_data;
    logic        reg_mismatch;

    modport source (output valid, kind, tx_byte, last, result_status, read_data,
                    reg_mismatch, input ready);
    modport sink (input valid, kind, tx_byte, last, result_status, read_data,
                  reg_mismatch, output ready);
endinterface

interface lmsfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== sv/lmsfe_res_queue.sv =====
// Small result queue that holds command frames and completions in order.
module lmsfe_res_queue #(
    parameter int DEPTH = lmsfe_pkg::RES_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lmsfe_pkg::t_res_entry i_data,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output lmsfe_pkg::t_res_entry o_head
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lmsfe_pkg::t_res_entry r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage is written in place; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("result queue count above depth");

    // A push into a full queue without a pop leaves the count unchanged.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full)
        else $error("result queue lost its full state");

    // Pointers differ whenever the queue is neither empty nor full.
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != FULL_CNT) |-> (r_wr_ptr != r_rd_ptr))
        else $error("result queue pointers inconsistent with count");

endmodule

// ===== sv/laser_module_serial_frame_engine.sv =====
// Top level of the laser frame engine: protocol state, timeout and result formatting.
// Results of an accepted item are queued and leave on the result channel in order.
// Throughput: one item per cycle is accepted while the result queue has space.
// A request yields a four-byte command run that leaves at one byte per cycle while
// the result channel is ready; queue depth and that channel set the sustained rate.
// Reset is synchronous and active low: idle, queue empty, timeout back to 100 ticks.
module laser_module_serial_frame_engine #(
    parameter int RES_DEPTH = lmsfe_pkg::RES_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmsfe_req_if.sink   i_req,
    lmsfe_res_if.source o_res,
    lmsfe_cfg_if.sink   i_cfg
);
    logic        r_waiting, n_waiting;
    logic [1:0]  r_bytes_seen, n_bytes_seen;
    logic [23:0] r_shift, n_shift;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_pending_reg, n_pending_reg;
    logic [15:0] r_timeout;
    logic [1:0]  r_byte_idx, n_byte_idx;

    lmsfe_pkg::t_res_entry push_data;
    lmsfe_pkg::t_res_entry head;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    logic        in_acc;
    logic [31:0] resp;
    logic [31:0] req_frame;
    logic [15:0] tick_count;

    assign i_req.ready = !q_full;
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_req.valid && i_req.ready;

    // Frames as they stand after this item.
    assign resp      = {r_shift, i_req.rx_byte};
    assign req_frame = {4'h0, i_req.write_en, 3'b000, i_req.reg_addr, i_req.write_data};
    assign tick_count = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    // Protocol state update and result generation for one item.
    always_comb begin
        n_waiting     = r_waiting;
        n_bytes_seen  = r_bytes_seen;
        n_shift       = r_shift;
        n_elapsed     = r_elapsed;
        n_pending_reg = r_pending_reg;
        push          = 1'b0;
        push_data     = '0;
        if (in_acc) begin
            unique case (i_req.mode)
                lmsfe_pkg::MODE_REQUEST: begin
                    if (!r_waiting) begin
                        n_waiting       = 1'b1;
                        n_bytes_seen    = '0;
                        n_shift         = '0;
                        n_elapsed       = '0;
                        n_pending_reg   = i_req.reg_addr;
                        push            = 1'b1;
                        push_data.kind  = lmsfe_pkg::KIND_CMD_BYTE;
                        push_data.frame = {lmsfe_pkg::bip4(req_frame), req_frame[27:0]};
                    end
                end
                lmsfe_pkg::MODE_RX_BYTE: begin
                    if (r_waiting) begin
                        n_shift      = resp[23:0];
                        n_bytes_seen = r_bytes_seen + 2'd1;
                        if (r_bytes_seen == 2'd3) begin
                            n_waiting      = 1'b0;
                            push           = 1'b1;
                            push_data.kind = lmsfe_pkg::KIND_COMPLETION;
                            if (resp[31:28] != lmsfe_pkg::bip4(resp)) begin
                                push_data.status = lmsfe_pkg::STATUS_FAIL;
                            end else if (resp[27]) begin
                                push_data.status = lmsfe_pkg::STATUS_COMM_ERR;
                            end else begin
                                push_data.status    = {1'b0, resp[25:24]};
                                push_data.read_data = resp[15:0];
                                push_data.mismatch  = (resp[23:16] != r_pending_reg);
                            end
                        end
                    end
                end
                lmsfe_pkg::MODE_TICK: begin
                    if (r_waiting) begin
                        n_elapsed = tick_count;
                        if (tick_count >= r_timeout) begin
                            n_waiting        = 1'b0;
                            n_bytes_seen     = '0;
                            push             = 1'b1;
                            push_data.kind   = lmsfe_pkg::KIND_COMPLETION;
                            push_data.status = lmsfe_pkg::STATUS_FAIL;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting     <= 1'b0;
            r_bytes_seen  <= '0;
            r_shift       <= '0;
            r_elapsed     <= '0;
            r_pending_reg <= '0;
            r_timeout     <= lmsfe_pkg::TIMEOUT_RESET;
            r_byte_idx    <= '0;
        end else begin
            r_waiting     <= n_waiting;
            r_bytes_seen  <= n_bytes_seen;
            r_shift       <= n_shift;
            r_elapsed     <= n_elapsed;
            r_pending_reg <= n_pending_reg;
            r_byte_idx    <= n_byte_idx;
            if (i_cfg.valid && i_cfg.ready) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

    lmsfe_res_queue #(
        .DEPTH (RES_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // Result formatting: a queued command frame leaves as four bytes, most significant first.
    always_comb begin
        o_res.valid         = !q_empty;
        o_res.kind          = head.kind;
        o_res.tx_byte       = '0;
        o_res.last          = 1'b0;
        o_res.result_status = '0;
        o_res.read_data     = '0;
        o_res.reg_mismatch  = 1'b0;
        n_byte_idx          = r_byte_idx;
        pop                 = 1'b0;
        if (head.kind == lmsfe_pkg::KIND_CMD_BYTE) begin
            unique case (r_byte_idx)
                2'd0: o_res.tx_byte = head.frame[31:24];
                2'd1: o_res.tx_byte = head.frame[23:16];
                2'd2: o_res.tx_byte = head.frame[15:8];
                2'd3: o_res.tx_byte = head.frame[7:0];
                default: o_res.tx_byte = '0;
            endcase
            o_res.last = (r_byte_idx == 2'd3);
        end else begin
            o_res.result_status = head.status;
            o_res.read_data     = head.read_data;
            o_res.reg_mismatch  = head.mismatch;
        end
        if (o_res.valid && o_res.ready) begin
            if (head.kind == lmsfe_pkg::KIND_COMPLETION) begin
                pop = 1'b1;
            end else begin
                n_byte_idx = r_byte_idx + 2'd1;
                pop        = (r_byte_idx == 2'd3);
            end
        end
    end

    // After the last byte of a run is taken the next run starts at byte 0.
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.kind == lmsfe_pkg::KIND_CMD_BYTE
         && o_res.last) |=> (r_byte_idx == 2'd0))
        else $error("command byte index did not wrap");

    // Partial responses exist only while a transaction is open.
    a_bytes_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_seen != 2'd0) |-> r_waiting)
        else $error("response bytes counted while idle");

    // A completion never carries a command byte or the last mark.
    a_completion_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == lmsfe_pkg::KIND_COMPLETION)
        |-> (o_res.tx_byte == 8'h00 && !o_res.last))
        else $error("completion carries command fields");

    // A request taken while busy leaves the pending register untouched.
    a_busy_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.mode == lmsfe_pkg::MODE_REQUEST && r_waiting)
        |=> $stable(r_pending_reg))
        else $error("request while busy changed the pending register");

endmodule
